@@ rtl/bdc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdc_pkg: shared constants and types for the bezier evaluator
// Point store sizes, function codes and status codes.
// ----------------------------------------------------------------------------
package bdc_pkg;

   localparam int MaxPoints  = 16;
   localparam int CoordWidth = 16;
   localparam int IdxWidth   = $clog2(MaxPoints);
   localparam int CntWidth   = $clog2(MaxPoints + 1);
   localparam int TWidth     = 17;
   localparam int RadWidth   = 12;
   localparam logic [RadWidth-1:0] RadReset = 12'd640;
   localparam logic [TWidth-1:0]   TOne     = 17'h10000;

   typedef logic [1:0] func_type;
   localparam func_type FuncAppend = 2'd0;
   localparam func_type FuncClear  = 2'd1;
   localparam func_type FuncMove   = 2'd2;
   localparam func_type FuncEval   = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type StatusOk    = 2'd0;
   localparam status_type StatusFull  = 2'd1;
   localparam status_type StatusShort = 2'd2;

endpackage

@@ rtl/bezier_de_casteljau_eval.sv @@
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval: control point store with curve evaluation
// Append, clear, move-by-radius and De Casteljau evaluation; move and evaluate each use one shared unit.
// ----------------------------------------------------------------------------
// Append and clear go directly to the done state; move checks the stored points
// (one shared distance unit, one point a cycle); evaluate copies the points,
// then runs one shared interpolator alternating x and y.
// One item at a time; ready is low while busy or a result waits.
// Reset (synchronous, active high) clears the point count, the sequencer and
// the result valid, and loads the grab radius with 640. The stores are not cleared.
module bezier_de_casteljau_eval (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bdc_pkg::func_type                 req_func,
   input  logic signed [bdc_pkg::CoordWidth-1:0] req_pos_x,
   input  logic signed [bdc_pkg::CoordWidth-1:0] req_pos_y,
   input  logic [bdc_pkg::TWidth-1:0]        req_curve_t,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bdc_pkg::status_type               rsp_status,
   output logic signed [bdc_pkg::CoordWidth-1:0] rsp_curve_x,
   output logic signed [bdc_pkg::CoordWidth-1:0] rsp_curve_y,
   output logic [bdc_pkg::CntWidth-1:0]      rsp_point_count,
   input  logic                              csr_wr_en,
   input  logic [bdc_pkg::RadWidth-1:0]      csr_wr_data
);
   import bdc_pkg::*;

   typedef enum logic [4:0] {
      StIdle = 5'b00001,
      StMove = 5'b00010,
      StCopy = 5'b00100,
      StEval = 5'b01000,
      StDone = 5'b10000
   } state_type;

   localparam int CW  = CoordWidth;
   localparam int DW  = CoordWidth + 1;
   localparam int SQW = 2 * DW + 1;

   state_type state_ff, state_in;
   logic [RadWidth-1:0] radius_ff;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic [CntWidth-1:0] lim_ff, lim_in;
   logic                axis_ff, axis_in;
   logic [CW-1:0]       px_ff, py_ff;
   logic [TWidth-1:0]   t_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [CW-1:0]       cx_ff, cy_ff;

   logic [CW-1:0] ctrl_x [MaxPoints];
   logic [CW-1:0] ctrl_y [MaxPoints];
   logic [CW-1:0] work_x [MaxPoints];
   logic [CW-1:0] work_y [MaxPoints];

   logic accept;
   assign req_ready = (state_ff == StIdle) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   // shared distance unit: one stored point against the move position
   logic signed [DW-1:0] dx, dy;
   logic [DW-1:0] adx, ady;
   logic [SQW-1:0] dist_sq, rad_sq;
   logic hit;
   always_comb begin
      dx = DW'($signed(px_ff)) - DW'($signed(ctrl_x[idx_ff]));
      dy = DW'($signed(py_ff)) - DW'($signed(ctrl_y[idx_ff]));
      adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
      ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
      dist_sq = SQW'(adx * adx) + SQW'(ady * ady);
      rad_sq  = SQW'(radius_ff * radius_ff);
      hit = (adx <= DW'(radius_ff)) && (ady <= DW'(radius_ff)) && (dist_sq <= rad_sq);
   end

   // shared interpolator: a + (b - a) * t, rounded to nearest
   localparam int PW = DW + TWidth + 2;
   logic [IdxWidth-1:0] idx_nx;
   logic signed [CW-1:0] ia, ib;
   logic signed [PW-1:0] iprod;
   logic signed [CW-1:0] ires;
   always_comb begin
      idx_nx = idx_ff + IdxWidth'(1);
      ia = axis_ff ? $signed(work_y[idx_ff]) : $signed(work_x[idx_ff]);
      ib = axis_ff ? $signed(work_y[idx_nx]) : $signed(work_x[idx_nx]);
      iprod = (PW'(ia) <<< 16) + PW'(DW'(ib) - DW'(ia)) * $signed({1'b0, t_ff})
              + PW'(32768);
      ires = iprod[CW+15:16];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      lim_in = lim_ff;
      axis_in = axis_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               idx_in = '0;
               axis_in = 1'b0;
               status_in = StatusOk;
               case (req_func)
                  FuncAppend: begin
                     if (count_ff >= CntWidth'(MaxPoints)) status_in = StatusFull;
                     else count_in = count_ff + CntWidth'(1);
                     state_in = StDone;
                  end
                  FuncClear: begin
                     count_in = '0;
                     state_in = StDone;
                  end
                  FuncMove: state_in = (count_ff == '0) ? StDone : StMove;
                  default: begin
                     if (count_ff < CntWidth'(3)) begin
                        status_in = StatusShort;
                        state_in = StDone;
                     end else state_in = StCopy;
                  end
               endcase
            end
         end
         StMove: begin
            idx_in = idx_nx;
            if (CntWidth'(idx_ff) + CntWidth'(1) >= count_ff) state_in = StDone;
         end
         StCopy: begin
            idx_in = idx_nx;
            if (CntWidth'(idx_ff) + CntWidth'(1) >= count_ff) begin
               idx_in = '0;
               lim_in = count_ff - CntWidth'(1);
               state_in = StEval;
            end
         end
         StEval: begin
            axis_in = !axis_ff;
            if (axis_ff) begin
               idx_in = idx_nx;
               if (CntWidth'(idx_ff) + CntWidth'(1) >= lim_ff) begin
                  idx_in = '0;
                  lim_in = lim_ff - CntWidth'(1);
                  if (lim_ff == CntWidth'(1)) state_in = StDone;
               end
            end
         end
         StDone: begin
            rsp_valid_in = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         radius_ff <= RadReset;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) radius_ff <= csr_wr_data;
      end
   end

   // payload registers and point stores
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      lim_ff <= lim_in;
      axis_ff <= axis_in;
      status_ff <= status_in;
      if (accept) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         t_ff <= (req_curve_t > TOne) ? TOne : req_curve_t;
         cx_ff <= '0;
         cy_ff <= '0;
         if (req_func == FuncAppend && count_ff < CntWidth'(MaxPoints)) begin
            ctrl_x[count_ff[IdxWidth-1:0]] <= req_pos_x;
            ctrl_y[count_ff[IdxWidth-1:0]] <= req_pos_y;
         end
      end
      if (state_ff == StMove && hit) begin
         ctrl_x[idx_ff] <= px_ff;
         ctrl_y[idx_ff] <= py_ff;
      end
      if (state_ff == StCopy) begin
         work_x[idx_ff] <= ctrl_x[idx_ff];
         work_y[idx_ff] <= ctrl_y[idx_ff];
      end
      if (state_ff == StEval) begin
         if (axis_ff) work_y[idx_ff] <= ires;
         else work_x[idx_ff] <= ires;
         if (lim_ff == CntWidth'(1) && axis_ff) cy_ff <= ires;
         if (lim_ff == CntWidth'(1) && !axis_ff) cx_ff <= ires;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_curve_x = cx_ff;
   assign rsp_curve_y = cy_ff;
   assign rsp_point_count = count_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(MaxPoints)) else $error("point count overflow");
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StIdle) |-> !rsp_valid_ff) else $error("result during work");
   a_eval_points: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StEval) |-> (lim_ff != '0) && (lim_ff < count_ff))
      else $error("interpolation limit out of range");
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StIdle) |=> $stable(count_ff)) else $error("count changed while busy");
endmodule
